// ----- hw/rtl/mla_pkg.sv -----
package mla_pkg;

  localparam int ByteW = 8;
  localparam int TextW = 32;
  localparam int LenW = 3;
  localparam int NumOps = 21;
  localparam int ParamDigitsDef = 8;

  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharOne   = 8'h31;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharNl    = 8'h0a;
  localparam logic [ByteW-1:0] CharSlash = 8'h2f;

  localparam logic ErrUnknownCmd = 1'b0;
  localparam logic ErrBadParam   = 1'b1;

  typedef struct packed {
    logic [TextW-1:0] text;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] code;
    logic [1:0]       nparams;
  } op_entry_t;

  typedef struct packed {
    logic             hit;
    logic [ByteW-1:0] code;
    logic [1:0]       nparams;
  } op_hit_t;

  // input word after the input register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] ch;
    logic             end_of_input;
  } stage_t;

  // result word handed to the output register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] out_byte;
    logic             is_error;
    logic             error_code;
    logic [ByteW-1:0] line_number;
  } res_t;

  // first character in the low byte
  localparam op_entry_t OpTable [NumOps] = '{
    '{32'h00444441, 3'd3, 8'h00, 2'd2},  // ADD
    '{32'h00425553, 3'd3, 8'h01, 2'd2},  // SUB
    '{32'h004C554D, 3'd3, 8'h02, 2'd2},  // MUL
    '{32'h00564944, 3'd3, 8'h03, 2'd2},  // DIV
    '{32'h00444F4D, 3'd3, 8'h04, 2'd2},  // MOD
    '{32'h00444E41, 3'd3, 8'h05, 2'd2},  // AND
    '{32'h0000524F, 3'd2, 8'h06, 2'd2},  // OR
    '{32'h00524F58, 3'd3, 8'h07, 2'd2},  // XOR
    '{32'h00544F4E, 3'd3, 8'h08, 2'd1},  // NOT
    '{32'h00545247, 3'd3, 8'h09, 2'd2},  // GRT
    '{32'h0053534C, 3'd3, 8'h0B, 2'd2},  // LSS
    '{32'h004C5145, 3'd3, 8'h0D, 2'd2},  // EQL
    '{32'h0051454E, 3'd3, 8'h0E, 2'd2},  // NEQ
    '{32'h00564F4D, 3'd3, 8'h0F, 2'd2},  // MOV
    '{32'h00524853, 3'd3, 8'h10, 2'd2},  // SHR
    '{32'h004C4853, 3'd3, 8'h11, 2'd2},  // SHL
    '{32'h0042534C, 3'd3, 8'h12, 2'd2},  // LSB
    '{32'h0042534D, 3'd3, 8'h13, 2'd2},  // MSB
    '{32'h00004E49, 3'd2, 8'h14, 2'd2},  // IN
    '{32'h0054554F, 3'd3, 8'h15, 2'd2},  // OUT
    '{32'h544C4148, 3'd4, 8'h16, 2'd2}   // HALT
  };

  // parallel compare against every mnemonic
  function automatic op_hit_t op_lookup(input logic [TextW-1:0] text,
                                        input logic [LenW-1:0] len);
    op_hit_t r;
    r = '0;
    for (int k = 0; k < NumOps; k++) begin
      if (OpTable[k].text == text && OpTable[k].len == len) begin
        r.hit     = 1'b1;
        r.code    = OpTable[k].code;
        r.nparams = OpTable[k].nparams;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mla_if.sv -----
interface mla_in_if;
  import mla_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] ch;
  logic             end_of_input;
  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface mla_out_if;
  import mla_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             is_error;
  logic             error_code;
  logic [ByteW-1:0] line_number;
  modport source (output valid, out_byte, is_error, error_code, line_number, input ready);
  modport sink (input valid, out_byte, is_error, error_code, line_number, output ready);
endinterface

// ----- hw/rtl/mla_in_stage.sv -----
module mla_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  mla_in_if.sink         in_i,
  input  logic           advance_i,
  output mla_pkg::stage_t stage_o
);
  import mla_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] ch_q;
  logic             eoi_q;
  logic             load;

  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q  <= in_i.ch;
      eoi_q <= in_i.end_of_input;
    end
  end

  assign stage_o = '{valid: valid_q, ch: ch_q, end_of_input: eoi_q};

endmodule

// ----- hw/rtl/mla_step.sv -----
module mla_step #(
  parameter int ParamDigits = mla_pkg::ParamDigitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mla_pkg::stage_t stage_i,
  input  logic            take_i,
  output mla_pkg::res_t   res_o
);
  import mla_pkg::*;

  localparam int DcW = $clog2(ParamDigits + 1);

  localparam logic [1:0] ModeMnem  = 2'd0;
  localparam logic [1:0] ModeParam = 2'd1;
  localparam logic [1:0] ModeStop  = 2'd2;

  logic [1:0]       mode_q, mode_d;
  logic [TextW-1:0] chars_q, chars_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] tail_q, tail_d;
  logic [DcW-1:0]   dc_q, dc_d;
  logic [1:0]       pl_q, pl_d;
  logic [ByteW-1:0] lc_q, lc_d;

  logic             fire;
  logic [ByteW-1:0] ch;
  logic             is_one;
  logic [ByteW-1:0] tail_shift;
  logic [1:0]       pl_dec;
  op_hit_t          hit;

  assign fire       = stage_i.valid && take_i;
  assign ch         = stage_i.ch;
  assign is_one     = (ch == CharOne);
  assign tail_shift = {tail_q[ByteW-2:0], is_one};
  assign pl_dec     = pl_q - 2'd1;
  assign hit        = op_lookup(chars_q, len_q);

  always_comb begin
    mode_d  = mode_q;
    chars_d = chars_q;
    len_d   = len_q;
    tail_d  = tail_q;
    dc_d    = dc_q;
    pl_d    = pl_q;
    lc_d    = lc_q;
    res_o   = '0;
    res_o.line_number = lc_q;
    if (fire) begin
      case (mode_q)
        ModeParam: begin
          if (stage_i.end_of_input) begin
            mode_d           = ModeStop;
            res_o.valid      = 1'b1;
            res_o.is_error   = 1'b1;
            res_o.error_code = ErrBadParam;
          end else if (dc_q < DcW'(ParamDigits)) begin
            if (ch inside {[CharZero:CharNine]}) begin
              tail_d = tail_shift;
              dc_d   = dc_q + DcW'(1);
            end else begin
              mode_d           = ModeStop;
              res_o.valid      = 1'b1;
              res_o.is_error   = 1'b1;
              res_o.error_code = ErrBadParam;
            end
          end else if (ch != CharNl) begin
            mode_d           = ModeStop;
            res_o.valid      = 1'b1;
            res_o.is_error   = 1'b1;
            res_o.error_code = ErrBadParam;
          end else begin
            // parameter byte reports the count after its own line
            res_o.valid       = 1'b1;
            res_o.out_byte    = tail_q;
            res_o.line_number = lc_q + 8'd1;
            tail_d = '0;
            dc_d   = '0;
            pl_d   = pl_dec;
            if (pl_dec == 2'd0) begin
              // the mnemonic line itself is counted last
              lc_d   = lc_q + 8'd2;
              mode_d = ModeMnem;
            end else begin
              lc_d = lc_q + 8'd1;
            end
          end
        end
        ModeMnem: begin
          if (stage_i.end_of_input) begin
            mode_d = ModeStop;
            if (len_q != '0) begin
              res_o.valid    = 1'b1;
              res_o.out_byte = tail_q;
            end
          end else if (ch == CharNl) begin
            if (len_q >= LenW'(2) && chars_q[2*ByteW-1:0] == {CharSlash, CharSlash}) begin
              chars_d = '0;
              len_d   = '0;
              tail_d  = '0;
              lc_d    = lc_q + 8'd1;
            end else if (hit.hit) begin
              chars_d        = '0;
              len_d          = '0;
              tail_d         = '0;
              mode_d         = ModeParam;
              pl_d           = hit.nparams;
              dc_d           = '0;
              res_o.valid    = 1'b1;
              res_o.out_byte = hit.code;
            end else begin
              mode_d           = ModeStop;
              res_o.valid      = 1'b1;
              res_o.is_error   = 1'b1;
              res_o.error_code = ErrUnknownCmd;
            end
          end else begin
            case (len_q)
              3'd0:    chars_d[7:0]   = ch;
              3'd1:    chars_d[15:8]  = ch;
              3'd2:    chars_d[23:16] = ch;
              3'd3:    chars_d[31:24] = ch;
              default: chars_d = chars_q;
            endcase
            tail_d = tail_shift;
            if (len_q < LenW'(5)) begin
              len_d = len_q + LenW'(1);
            end
          end
        end
        default: begin
          // stopped, no result until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeMnem;
      chars_q <= '0;
      len_q   <= '0;
      tail_q  <= '0;
      dc_q    <= '0;
      pl_q    <= '0;
      lc_q    <= 8'd1;
    end else begin
      mode_q  <= mode_d;
      chars_q <= chars_d;
      len_q   <= len_d;
      tail_q  <= tail_d;
      dc_q    <= dc_d;
      pl_q    <= pl_d;
      lc_q    <= lc_d;
    end
  end

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_error |=> mode_q == ModeStop)
    else $error("error word did not stop the block");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mode_q != ModeMnem && mode_q != ModeParam |-> !res_o.valid)
    else $error("result produced while stopped");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= DcW'(ParamDigits))
    else $error("digit count past parameter width");

  a_param_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeParam |-> chars_q == '0 && len_q == '0)
    else $error("mnemonic buffer not cleared in parameter mode");

endmodule

// ----- hw/rtl/mla_out_stage.sv -----
module mla_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mla_pkg::res_t res_i,
  output logic          can_take_o,
  mla_out_if.source     out_o
);
  import mla_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             err_q;
  logic             code_q;
  logic [ByteW-1:0] line_q;

  assign can_take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && res_i.valid) begin
      byte_q <= res_i.out_byte;
      err_q  <= res_i.is_error;
      code_q <= res_i.error_code;
      line_q <= res_i.line_number;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.is_error    = err_q;
  assign out_o.error_code  = code_q;
  assign out_o.line_number = line_q;

endmodule

// ----- hw/rtl/mnemonic_line_assembler_top.sv -----
// Line assembler for a fixed set of 21 mnemonics: one text character per word in, zero or one
// assembled byte per character out (opcode, parameter byte, end-of-text byte, or an error
// that stops the block until reset). The block takes one character every cycle; a character
// goes through the input register, the mnemonic/parameter decode and the result register
// before its result is on the outputs. The only thing
// that holds the input back is a full result register that the sink does not take.
module mnemonic_line_assembler_top #(
  parameter int ParamDigits = mla_pkg::ParamDigitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mla_in_if.sink    in_i,
  mla_out_if.source out_o
);
  import mla_pkg::*;

  stage_t stage;
  res_t   res;
  logic   can_take;
  logic   advance;

  assign advance = stage.valid && can_take;

  mla_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  mla_step #(
    .ParamDigits (ParamDigits)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_i  (can_take),
    .res_o   (res)
  );

  mla_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

endmodule
